// ----- rtl/mmu_tlb_pkg.sv -----
// Shared types and constants for the two-level MMU TLB.
// Used by the controller, datapath, divider and top level; depends on nothing.
`default_nettype none

package mmu_tlb_pkg;

   // Fixed field widths.
   localparam int ADDR_W      = 32;
   localparam int PAGE_SIZE_W = 16;
   localparam int TABLE_W     = 11;
   localparam int TLB_SIZE_W  = 5;
   localparam int SECOND_W    = 10;
   localparam int REQ_FRAME_W = 16;
   localparam int FUNC_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 128;

   // The divider retires two quotient bits per cycle.
   localparam int DIV_STEPS   = ADDR_W / 2;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // Largest table size that is honored.
   localparam logic [TABLE_W-1:0] TABLE_MAX = 11'd1024;

   // Operation codes carried on req_tuser.
   localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILL      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH     = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TLB_SIZE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LRU_MODE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_SIZE     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_ENTRIES = 2'd3;

   // Configuration reset values.
   localparam logic [TLB_SIZE_W-1:0]  RST_TLB_SIZE      = 5'd4;
   localparam logic                   RST_LRU_MODE      = 1'b0;
   localparam logic [PAGE_SIZE_W-1:0] RST_PAGE_SIZE     = 16'd64;
   localparam logic [TABLE_W-1:0]     RST_TABLE_ENTRIES = 11'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;        // latch the incoming word
      logic div_start;      // start a division pass
      logic div_sel_index;  // divide the page number by the table size
      logic save_page;      // keep page number and offset, build match vector
      logic scan_step;      // advance the lookup scan by one entry
      logic save_index;     // keep both table indexes
      logic mul;            // form the physical address of the hit
      logic drop;           // remove one entry and close the gap
      logic drop_oldest;    // the removed entry is the oldest one
      logic append;         // add the pending entry as the newest
      logic flush;          // empty the list
      logic load_out;       // move the result into the output register
   } tlb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic              div_done;
      logic              scan_done;
      logic              hit;
      logic              full;
      logic              lru;
      logic [FUNC_W-1:0] func;
      logic              out_free;
   } tlb_status_type;

endpackage

`default_nettype wire

// ----- rtl/mmu_tlb_div.sv -----
// Radix-4 restoring divider for a 32-bit dividend and a 16-bit divisor.
// Depends on mmu_tlb_pkg for widths and the step count.
`default_nettype none

module mmu_tlb_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [mmu_tlb_pkg::ADDR_W-1:0]      dividend,
   input  wire logic [mmu_tlb_pkg::PAGE_SIZE_W-1:0] divisor,
   output logic                                     done,
   output logic [mmu_tlb_pkg::ADDR_W-1:0]           quotient,
   output logic [mmu_tlb_pkg::PAGE_SIZE_W-1:0]      remainder
);
   import mmu_tlb_pkg::*;

   localparam int TRIAL_W = PAGE_SIZE_W + 2;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ADDR_W-1:0]       quot_ff, quot_in;
   logic [PAGE_SIZE_W-1:0]  rem_ff, rem_in;
   logic [PAGE_SIZE_W-1:0]  dvs_ff, dvs_in;
   logic [TRIAL_W-1:0]      trial, d1, d2, d3;
   logic [1:0]              digit;
   logic [TRIAL_W-1:0]      diff;

   // One step: pick the largest multiple of the divisor that fits.
   always_comb begin
      trial = {rem_ff, quot_ff[ADDR_W-1 -: 2]};
      d1    = {2'b00, dvs_ff};
      d2    = {1'b0, dvs_ff, 1'b0};
      d3    = d1 + d2;
      if (trial >= d3) begin
         digit = 2'd3;
         diff  = trial - d3;
      end else if (trial >= d2) begin
         digit = 2'd2;
         diff  = trial - d2;
      end else if (trial >= d1) begin
         digit = 2'd1;
         diff  = trial - d1;
      end else begin
         digit = 2'd0;
         diff  = trial;
      end
   end

   // Iteration control and operand registers.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[ADDR_W-3:0], digit};
         rem_in  = diff[PAGE_SIZE_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/mmu_tlb_dp.sv -----
// Datapath of the TLB: configuration registers, address split, entry list,
// lookup scan, physical address multiply and the output register.
// Depends on mmu_tlb_pkg and mmu_tlb_div.
`default_nettype none

module mmu_tlb_dp #(
   parameter int TLB_DEPTH  = 16,
   parameter int FRAME_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [mmu_tlb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mmu_tlb_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic [mmu_tlb_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [mmu_tlb_pkg::ADDR_W-1:0]      req_address,
   input  wire logic [mmu_tlb_pkg::REQ_FRAME_W-1:0] req_frame,
   input  wire mmu_tlb_pkg::tlb_cmd_type            cmd,
   output mmu_tlb_pkg::tlb_status_type              status,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tvalid,
   output logic                                     rsp_hit,
   output logic [mmu_tlb_pkg::ADDR_W-1:0]           rsp_physical_address,
   output logic [mmu_tlb_pkg::ADDR_W-1:0]           rsp_page_number,
   output logic [mmu_tlb_pkg::PAGE_SIZE_W-1:0]      rsp_page_offset,
   output logic [mmu_tlb_pkg::ADDR_W-1:0]           rsp_first_level_index,
   output logic [mmu_tlb_pkg::SECOND_W-1:0]         rsp_second_level_index
);
   import mmu_tlb_pkg::*;

   localparam int CNT_W  = $clog2(TLB_DEPTH + 1);
   localparam int IDX_W  = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
   localparam int SZ_W   = (CNT_W > TLB_SIZE_W) ? CNT_W : TLB_SIZE_W;
   localparam int PROD_W = FRAME_BITS + PAGE_SIZE_W;

   // Configuration registers.
   logic [TLB_SIZE_W-1:0]  tlb_size_ff;
   logic                   lru_mode_ff;
   logic [PAGE_SIZE_W-1:0] page_size_ff;
   logic [TABLE_W-1:0]     table_entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_size_ff      <= RST_TLB_SIZE;
         lru_mode_ff      <= RST_LRU_MODE;
         page_size_ff     <= RST_PAGE_SIZE;
         table_entries_ff <= RST_TABLE_ENTRIES;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TLB_SIZE:      tlb_size_ff      <= csr_data[TLB_SIZE_W-1:0];
            CSR_LRU_MODE:      lru_mode_ff      <= csr_data[0];
            CSR_PAGE_SIZE:     page_size_ff     <= csr_data[PAGE_SIZE_W-1:0];
            CSR_TABLE_ENTRIES: table_entries_ff <= csr_data[TABLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective page size, table size and list capacity after clamping.
   logic [PAGE_SIZE_W-1:0] ps_eff;
   logic [TABLE_W-1:0]     te_eff;
   logic [SZ_W-1:0]        size_ext;
   logic [CNT_W-1:0]       cap;

   always_comb begin
      ps_eff = (page_size_ff == '0) ? PAGE_SIZE_W'(1) : page_size_ff;
      if (table_entries_ff == '0) begin
         te_eff = TABLE_W'(1);
      end else if (table_entries_ff > TABLE_MAX) begin
         te_eff = TABLE_MAX;
      end else begin
         te_eff = table_entries_ff;
      end
      size_ext = SZ_W'(tlb_size_ff);
      if (size_ext == '0) begin
         cap = CNT_W'(1);
      end else if (size_ext > SZ_W'(TLB_DEPTH)) begin
         cap = CNT_W'(TLB_DEPTH);
      end else begin
         cap = size_ext[CNT_W-1:0];
      end
   end

   // Shared divider: address by page size, then page number by table size.
   logic                   div_done;
   logic [ADDR_W-1:0]      div_quot;
   logic [PAGE_SIZE_W-1:0] div_rem;
   logic [ADDR_W-1:0]      div_dividend;
   logic [PAGE_SIZE_W-1:0] div_divisor;

   assign div_dividend = cmd.div_sel_index ? div_quot : req_address;
   assign div_divisor  = cmd.div_sel_index ? PAGE_SIZE_W'(te_eff) : ps_eff;

   mmu_tlb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Per-word working registers.
   logic [FUNC_W-1:0]      func_ff;
   logic [FRAME_BITS-1:0]  new_frame_ff;
   logic [ADDR_W-1:0]      page_ff;
   logic [PAGE_SIZE_W-1:0] offset_ff;
   logic [ADDR_W-1:0]      first_ff;
   logic [SECOND_W-1:0]    second_ff;
   logic [ADDR_W-1:0]      phys_ff;

   // Entry list, index 0 oldest.
   logic [ADDR_W-1:0]      entry_page_ff  [TLB_DEPTH];
   logic [FRAME_BITS-1:0]  entry_frame_ff [TLB_DEPTH];
   logic [ADDR_W-1:0]      up_page        [TLB_DEPTH];
   logic [FRAME_BITS-1:0]  up_frame       [TLB_DEPTH];
   logic [CNT_W-1:0]       count_ff;
   logic [TLB_DEPTH-1:0]   match_ff, match_in;
   logic [TLB_DEPTH-1:0]   drop_mask;
   logic [IDX_W-1:0]       drop_pos;

   // Lookup scan state.
   logic [CNT_W-1:0]       scan_idx_ff;
   logic                   scan_done_ff;
   logic                   hit_ff;
   logic [IDX_W-1:0]       hit_idx_ff;

   // Hit frame and the product for the physical address.
   logic [FRAME_BITS-1:0]  hit_frame;
   logic [PROD_W-1:0]      prod;

   assign hit_frame = entry_frame_ff[hit_idx_ff];
   assign prod      = PROD_W'(hit_frame) * PROD_W'(ps_eff);
   assign drop_pos  = cmd.drop_oldest ? '0 : hit_idx_ff;

   // Each cell's view of its newer neighbor, for closing a gap.
   for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
      if (g < TLB_DEPTH - 1) begin : g_mid
         assign up_page[g]  = entry_page_ff[g+1];
         assign up_frame[g] = entry_frame_ff[g+1];
      end else begin : g_top
         assign up_page[g]  = entry_page_ff[g];
         assign up_frame[g] = entry_frame_ff[g];
      end
      assign drop_mask[g] = (IDX_W'(g) >= drop_pos) && (CNT_W'(g + 1) < count_ff);
      assign match_in[g]  = (div_quot == entry_page_ff[g]);
   end

   // Entry storage; entries are undefined until written.
   always_ff @(posedge clock) begin
      for (int j = 0; j < TLB_DEPTH; j++) begin
         if (cmd.drop && drop_mask[j]) begin
            entry_page_ff[j]  <= up_page[j];
            entry_frame_ff[j] <= up_frame[j];
         end else if (cmd.append && (count_ff[IDX_W-1:0] == IDX_W'(j))) begin
            entry_page_ff[j]  <= page_ff;
            entry_frame_ff[j] <= new_frame_ff;
         end
      end
   end

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.flush) begin
         count_ff <= '0;
      end else if (cmd.drop) begin
         count_ff <= count_ff - 1'b1;
      end else if (cmd.append) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Lookup scan over the registered match vector, oldest entry first.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         scan_done_ff <= 1'b1;
         hit_ff       <= 1'b0;
      end else if (cmd.capture) begin
         hit_ff       <= 1'b0;
      end else if (cmd.save_page) begin
         scan_idx_ff  <= '0;
         scan_done_ff <= (func_ff != FUNC_TRANSLATE);
         hit_ff       <= 1'b0;
      end else if (cmd.scan_step && !scan_done_ff) begin
         if (scan_idx_ff >= count_ff) begin
            scan_done_ff <= 1'b1;
         end else if (match_ff[scan_idx_ff[IDX_W-1:0]]) begin
            scan_done_ff <= 1'b1;
            hit_ff       <= 1'b1;
         end else begin
            scan_idx_ff  <= scan_idx_ff + 1'b1;
         end
      end
   end

   // Word payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff      <= req_func;
         new_frame_ff <= FRAME_BITS'(req_frame);
         phys_ff      <= '0;
      end
      if (cmd.save_page) begin
         page_ff   <= div_quot;
         offset_ff <= div_rem;
         match_ff  <= match_in;
      end
      if (cmd.save_index) begin
         first_ff  <= div_quot;
         second_ff <= div_rem[SECOND_W-1:0];
      end
      if (cmd.scan_step && !scan_done_ff) begin
         hit_idx_ff <= scan_idx_ff[IDX_W-1:0];
      end
      if (cmd.mul) begin
         phys_ff      <= ADDR_W'(prod) + ADDR_W'(offset_ff);
         new_frame_ff <= hit_frame;
      end
   end

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [ADDR_W-1:0]      rsp_phys_ff;
   logic [ADDR_W-1:0]      rsp_page_ff;
   logic [PAGE_SIZE_W-1:0] rsp_offset_ff;
   logic [ADDR_W-1:0]      rsp_first_ff;
   logic [SECOND_W-1:0]    rsp_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_hit_ff    <= hit_ff;
         rsp_phys_ff   <= phys_ff;
         rsp_page_ff   <= page_ff;
         rsp_offset_ff <= offset_ff;
         rsp_first_ff  <= first_ff;
         rsp_second_ff <= second_ff;
      end
   end

   assign rsp_tvalid             = rsp_valid_ff;
   assign rsp_hit                = rsp_hit_ff;
   assign rsp_physical_address   = rsp_phys_ff;
   assign rsp_page_number        = rsp_page_ff;
   assign rsp_page_offset        = rsp_offset_ff;
   assign rsp_first_level_index  = rsp_first_ff;
   assign rsp_second_level_index = rsp_second_ff;

   // Status to the controller.
   always_comb begin
      status.div_done  = div_done;
      status.scan_done = scan_done_ff;
      status.hit       = hit_ff;
      status.full      = (count_ff >= cap);
      status.lru       = lru_mode_ff;
      status.func      = func_ff;
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

// ----- rtl/mmu_tlb_ctrl.sv -----
// Controller state machine of the TLB: sequences split, lookup, list update
// and result hand-off. Depends on mmu_tlb_pkg.
`default_nettype none

module mmu_tlb_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire mmu_tlb_pkg::tlb_status_type status,
   output mmu_tlb_pkg::tlb_cmd_type         cmd
);
   import mmu_tlb_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DIV_PAGE  = 3'd1;
   localparam logic [2:0] S_DIV_INDEX = 3'd2;
   localparam logic [2:0] S_BRANCH    = 3'd3;
   localparam logic [2:0] S_MUL       = 3'd4;
   localparam logic [2:0] S_DROP      = 3'd5;
   localparam logic [2:0] S_EVICT     = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         // Take a word and start splitting its address.
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture   = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_DIV_PAGE;
            end
         end
         // Page number known: start the table split and the lookup.
         S_DIV_PAGE: begin
            if (status.div_done) begin
               cmd.save_page     = 1'b1;
               cmd.div_start     = 1'b1;
               cmd.div_sel_index = 1'b1;
               state_in          = S_DIV_INDEX;
            end
         end
         S_DIV_INDEX: begin
            cmd.scan_step     = 1'b1;
            cmd.div_sel_index = 1'b1;
            if (status.div_done) begin
               cmd.save_index = 1'b1;
               state_in       = S_BRANCH;
            end
         end
         // Lookup finished: act on the operation.
         S_BRANCH: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               case (status.func)
                  FUNC_TRANSLATE: state_in = status.hit ? S_MUL : S_DONE;
                  FUNC_FILL:      state_in = S_EVICT;
                  FUNC_FLUSH: begin
                     cmd.flush = 1'b1;
                     state_in  = S_DONE;
                  end
                  default:        state_in = S_DONE;
               endcase
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = status.lru ? S_DROP : S_DONE;
         end
         // Move the hit entry to the newest place.
         S_DROP: begin
            cmd.drop = 1'b1;
            state_in = S_EVICT;
         end
         // Evict oldest entries until there is room, then append.
         S_EVICT: begin
            if (status.full) begin
               cmd.drop        = 1'b1;
               cmd.drop_oldest = 1'b1;
            end else begin
               cmd.append = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/two_level_mmu_tlb_top.sv -----
// Two-level MMU TLB top level. One word at a time: each word takes two divider passes of 16
// radix-4 steps; an LRU hit, a fill and each evicted entry add list updates. The next word
// is taken the cycle after the result is loaded; a result waits in the output register
// while the next word runs. Synchronous reset restores defaults, empties the list.
`default_nettype none

module two_level_mmu_tlb_top #(
   parameter int TLB_DEPTH  = 16,
   parameter int FRAME_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // logical_address [31:0], frame [47:32]
   input  wire logic [mmu_tlb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func [1:0]
   input  wire logic [mmu_tlb_pkg::FUNC_W-1:0]      req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // physical_address [31:0], page_number [63:32], page_offset [79:64],
   // first_level_index [111:80], second_level_index [121:112], zero above
   output logic [mmu_tlb_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // hit [0]
   output logic                                     rsp_tuser,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mmu_tlb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mmu_tlb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mmu_tlb_pkg::*;

   tlb_cmd_type            cmd;
   tlb_status_type         status;
   logic [ADDR_W-1:0]      phys, page, first;
   logic [PAGE_SIZE_W-1:0] offset;
   logic [SECOND_W-1:0]    second;

   // Configuration writes are taken in any cycle.
   assign csr_ready = 1'b1;

   mmu_tlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mmu_tlb_dp #(
      .TLB_DEPTH  (TLB_DEPTH),
      .FRAME_BITS (FRAME_BITS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_func               (req_tuser),
      .req_address            (req_tdata[ADDR_W-1:0]),
      .req_frame              (req_tdata[ADDR_W +: REQ_FRAME_W]),
      .cmd                    (cmd),
      .status                 (status),
      .rsp_tready             (rsp_tready),
      .rsp_tvalid             (rsp_tvalid),
      .rsp_hit                (rsp_tuser),
      .rsp_physical_address   (phys),
      .rsp_page_number        (page),
      .rsp_page_offset        (offset),
      .rsp_first_level_index  (first),
      .rsp_second_level_index (second)
   );

   // Pack the result word, first field in the lowest bits.
   assign rsp_tdata = RSP_DATA_W'({second, first, offset, page, phys});

endmodule

`default_nettype wire

// ----- rtl/mmu_tlb_checker.sv -----
// Port-level checks for the two-level MMU TLB, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module mmu_tlb_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata,
   input wire logic         rsp_tuser
);

   // A result word that is not taken holds steady.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // A miss or a non-translate word reports a zero physical address.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero physical address without a hit");

   // The block works on one word at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // Padding bits of the result word stay zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[127:122] == 6'd0)
      else $error("padding bits set in result word");

endmodule

bind two_level_mmu_tlb_top mmu_tlb_checker u_checker (.*);

`default_nettype wire

// ----- sim/tlb_checker.sv -----
`timescale 1ns / 1ps
// Response checker for the two-level MMU TLB: watches the request, register and
// response channels, keeps its own copy of the TLB and compares every response.
// Depends on mmu_tlb_pkg for widths, operation codes and register indexes.
module tlb_checker #(
   parameter int TLB_DEPTH  = 16,
   parameter int FRAME_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [mmu_tlb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [mmu_tlb_pkg::FUNC_W-1:0]      req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [mmu_tlb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                                rsp_tuser,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [mmu_tlb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mmu_tlb_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                  mismatches,
   output int                                  pending,
   output int                                  hits_seen
);
   import mmu_tlb_pkg::*;

   localparam logic [63:0] FRAME_MASK = (FRAME_BITS >= 32) ? 64'hFFFF_FFFF
                                                           : (64'd1 << FRAME_BITS) - 64'd1;

   // One response word, split into its fields.
   typedef struct packed {
      logic        hit;
      logic [31:0] phys_addr;
      logic [31:0] page_num;
      logic [15:0] page_off;
      logic [31:0] first_idx;
      logic [9:0]  second_idx;
   } xlate_result_type;

   // Register copies, written as the block sees them.
   logic [TLB_SIZE_W-1:0]  tlb_size_r;
   logic                   lru_r;
   logic [PAGE_SIZE_W-1:0] page_size_r;
   logic [TABLE_W-1:0]     table_r;

   // The entry list, oldest at index zero.
   logic [31:0] tlb_page  [TLB_DEPTH];
   logic [31:0] tlb_frame [TLB_DEPTH];
   int          tlb_count;

   xlate_result_type expected_q[$];
   int               responses;

   // Remove one entry and close the gap behind it.
   function automatic void remove_entry(int pos);
      for (int i = pos; i + 1 < tlb_count; i++) begin
         tlb_page[i]  = tlb_page[i + 1];
         tlb_frame[i] = tlb_frame[i + 1];
      end
      tlb_count--;
   endfunction

   // Add an entry as the newest, evicting the oldest until it fits.
   function automatic void insert_newest(logic [31:0] page, logic [31:0] frm);
      int cap;
      cap = int'(tlb_size_r);
      if (cap < 1) cap = 1;
      if (cap > TLB_DEPTH) cap = TLB_DEPTH;
      while (tlb_count >= cap) remove_entry(0);
      tlb_page[tlb_count]  = page;
      tlb_frame[tlb_count] = frm;
      tlb_count++;
   endfunction

   // Work out the response to one request word and update the list.
   function automatic xlate_result_type predict_word(logic [FUNC_W-1:0] func, logic [31:0] addr,
                                                     logic [15:0] frame);
      xlate_result_type r;
      logic [31:0]      ps, te, page, frm;
      logic [63:0]      prod;
      int               found;
      ps = (page_size_r == '0) ? 32'd1 : 32'(page_size_r);
      te = (table_r == '0) ? 32'd1 : ((table_r > TABLE_MAX) ? 32'(TABLE_MAX) : 32'(table_r));
      page = addr / ps;
      r.hit        = 1'b0;
      r.phys_addr  = '0;
      r.page_num   = page;
      r.page_off   = 16'(addr % ps);
      r.first_idx  = page / te;
      r.second_idx = 10'(page % te);
      frm = 32'(64'(frame) & FRAME_MASK);
      found = -1;
      case (func)
         FUNC_TRANSLATE: begin
            // The oldest matching entry wins when pages repeat.
            for (int i = 0; i < tlb_count; i++)
               if (found < 0 && tlb_page[i] == page) found = i;
            if (found >= 0) begin
               r.hit = 1'b1;
               prod = 64'(tlb_frame[found]) * 64'(ps) + 64'(r.page_off);
               r.phys_addr = prod[31:0];
               if (lru_r) begin
                  frm = tlb_frame[found];
                  remove_entry(found);
                  insert_newest(page, frm);
               end
            end
         end
         FUNC_FILL:  insert_newest(page, frm);
         FUNC_FLUSH: tlb_count = 0;
         default: ;
      endcase
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d: %s expected %h, got %h", responses, name, want, got);
      end
   endfunction

   // Sample all three channels at the rising edge.
   always @(posedge clock) begin : watch
      xlate_result_type want;
      if (reset) begin
         tlb_size_r  = RST_TLB_SIZE;
         lru_r       = RST_LRU_MODE;
         page_size_r = RST_PAGE_SIZE;
         table_r     = RST_TABLE_ENTRIES;
         tlb_count   = 0;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with nothing expected: hit %b data %h",
                           responses, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_q.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_tuser));
               check_field("physical_address", want.phys_addr, rsp_tdata[31:0]);
               check_field("page_number", want.page_num, rsp_tdata[63:32]);
               check_field("page_offset", 32'(want.page_off), 32'(rsp_tdata[79:64]));
               check_field("first_level_index", want.first_idx, rsp_tdata[111:80]);
               check_field("second_level_index", 32'(want.second_idx),
                           32'(rsp_tdata[121:112]));
               check_field("padding", 32'd0, 32'(rsp_tdata[127:122]));
               if (want.hit) hits_seen++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TLB_SIZE:      tlb_size_r  = csr_data[TLB_SIZE_W-1:0];
               CSR_LRU_MODE:      lru_r       = csr_data[0];
               CSR_PAGE_SIZE:     page_size_r = csr_data[PAGE_SIZE_W-1:0];
               CSR_TABLE_ENTRIES: table_r     = csr_data[TABLE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(predict_word(req_tuser, req_tdata[31:0], req_tdata[47:32]));
      end
      pending = expected_q.size();
   end

endmodule

// ----- sim/tb_two_level_mmu_tlb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the two-level MMU TLB: drives request words and register
// writes, paces the response side and reports the verdict.
// Depends on mmu_tlb_pkg, two_level_mmu_tlb_top and tlb_checker.
module tb_two_level_mmu_tlb_top;
   import mmu_tlb_pkg::*;

   localparam int PERIOD_NS       = 20;
   localparam int TLB_DEPTH       = 16;
   localparam int FRAME_BITS      = 16;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int BURST_ITEMS     = 12;
   localparam int LONG_HOLD       = 400;
   localparam int MAX_GAP         = 40;
   localparam int END_SETTLE      = 80;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [FUNC_W-1:0]      req_tuser  = FUNC_TRANSLATE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_TLB_SIZE;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int mismatches, pending, hits_seen;

   // Pacing knobs: idle and stall chances in percent of cycles, and the hold-off counters.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // Stimulus bookkeeping: the register values that shape the addresses.
   logic [TLB_SIZE_W-1:0]  cfg_tlb = RST_TLB_SIZE;
   logic [PAGE_SIZE_W-1:0] cfg_ps  = RST_PAGE_SIZE;
   int words_sent;
   int regs_written;

   always #(PERIOD_NS / 2) clock = ~clock;

   two_level_mmu_tlb_top #(
      .TLB_DEPTH(TLB_DEPTH),
      .FRAME_BITS(FRAME_BITS)
   ) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   tlb_checker #(
      .TLB_DEPTH(TLB_DEPTH),
      .FRAME_BITS(FRAME_BITS)
   ) scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .pending(pending), .hits_seen(hits_seen)
   );

   // Response side: random stalls, plus a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one request word, after a random idle gap, and wait for its handshake.
   task automatic send_word(logic [FUNC_W-1:0] func, logic [31:0] addr, logic [15:0] frame);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {frame, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // Stop offering words and wait for every outstanding response.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      if (index == CSR_TLB_SIZE) cfg_tlb = value[TLB_SIZE_W-1:0];
      if (index == CSR_PAGE_SIZE) cfg_ps = value;
      regs_written++;
   endtask

   // Only called once the block is drained.
   task automatic set_all_regs(logic [15:0] tlb, logic [15:0] lru, logic [15:0] ps,
                               logic [15:0] te);
      write_reg(CSR_TLB_SIZE, tlb);
      write_reg(CSR_LRU_MODE, lru);
      write_reg(CSR_PAGE_SIZE, ps);
      write_reg(CSR_TABLE_ENTRIES, te);
   endtask

   // An address inside the given page under the current page size.
   function automatic logic [31:0] pool_address(logic [31:0] page);
      logic [31:0] ps;
      logic [63:0] sum;
      ps  = (cfg_ps == '0) ? 32'd1 : 32'(cfg_ps);
      sum = 64'(page) * 64'(ps) + 64'($urandom_range(ps - 1, 0));
      if (sum > 64'hFFFF_FFFF) sum = 64'(page) * 64'(ps);
      return sum[31:0];
   endfunction

   initial begin : stimulus
      logic [31:0] pool [20];
      logic [31:0] max_page, pg;
      logic [15:0] tlb_v, lru_v, ps_v, te_v;
      int          pool_n, cap, r, items;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings, four entries, FIFO order, page size 64.
      send_word(FUNC_TRANSLATE, 32'h0000_0000, 16'h0000);   // empty list misses
      send_word(FUNC_FILL,      32'h0000_1234, 16'hFFFF);
      send_word(FUNC_TRANSLATE, 32'h0000_1234, 16'h0000);   // hit, largest frame
      send_word(FUNC_FILL,      32'h0000_1200, 16'h0005);   // same page filled twice
      send_word(FUNC_TRANSLATE, 32'h0000_1210, 16'h0000);   // oldest duplicate answers
      send_word(FUNC_TRANSLATE, 32'hFFFF_FFFF, 16'hFFFF);   // miss at the top address
      send_word(FUNC_FILL,      32'hFFFF_FFFF, 16'h0000);
      send_word(FUNC_TRANSLATE, 32'hFFFF_FFC0, 16'h0000);
      send_word(FUNC_UNUSED,    32'hA5A5_A5A5, 16'h5A5A);   // unused code changes nothing
      send_word(FUNC_FILL,      32'h0001_0000, 16'h1234);
      send_word(FUNC_FILL,      32'h0002_0000, 16'h4321);   // full list evicts the oldest
      send_word(FUNC_TRANSLATE, 32'h0000_1234, 16'h0000);
      send_word(FUNC_FLUSH,     32'h1234_5678, 16'hFFFF);
      send_word(FUNC_TRANSLATE, 32'h0000_1234, 16'h0000);   // gone after the flush

      // Zero page size, zero table size and zero capacity, LRU on.
      drain();
      set_all_regs(16'd0, 16'd1, 16'd0, 16'd0);
      send_word(FUNC_FILL,      32'h89AB_CDEF, 16'h00FF);
      send_word(FUNC_TRANSLATE, 32'h89AB_CDEF, 16'h0000);
      send_word(FUNC_FILL,      32'h0000_0007, 16'h0001);

      // Oversized capacity and table size, largest page size, wrapping address.
      drain();
      set_all_regs(16'd31, 16'd1, 16'hFFFF, 16'd2047);
      send_word(FUNC_FILL,      32'hFFFF_FFFF, 16'hFFFF);
      send_word(FUNC_FILL,      32'h1234_5678, 16'h8000);
      send_word(FUNC_TRANSLATE, 32'hFFFF_FFFF, 16'h0000);
      send_word(FUNC_TRANSLATE, 32'h1234_5678, 16'h0000);
      for (int k = 1; k <= 4; k++) send_word(FUNC_FILL, 32'(k) << 16, 16'(k));

      // Capacity lowered below the entry count: the next fill evicts several.
      drain();
      write_reg(CSR_TLB_SIZE, 16'd2);
      send_word(FUNC_FILL,      32'h0005_0000, 16'h0009);
      send_word(FUNC_TRANSLATE, 32'h0004_0000, 16'h0000);
      send_word(FUNC_TRANSLATE, 32'hFFFF_FFFF, 16'h0000);

      // Random phases: new settings, a new working set of pages and a new pacing mix.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph == 0) begin
            set_all_regs(16'd1, 16'd0, 16'd1, 16'd1);
         end else if (ph == PHASES - 1) begin
            set_all_regs(16'd16, 16'd1, 16'hFFFF, 16'd1024);
         end else begin
            tlb_v = 16'($urandom_range(16, 1));
            if ($urandom_range(7) == 0) tlb_v = 16'($urandom_range(31, 17));
            lru_v = 16'($urandom_range(1));
            r = $urandom_range(9);
            if (r == 0) ps_v = 16'd0;
            else if (r == 1) ps_v = 16'hFFFF;
            else if (r < 6) ps_v = 16'($urandom_range(256, 1));
            else ps_v = 16'($urandom_range(65535, 1));
            r = $urandom_range(9);
            if (r == 0) te_v = 16'd0;
            else if (r == 1) te_v = 16'($urandom_range(2047, 1025));
            else if (r < 6) te_v = 16'($urandom_range(16, 1));
            else te_v = 16'($urandom_range(1024, 1));
            set_all_regs(tlb_v, lru_v, ps_v, te_v);
         end

         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase

         // A few more pages than the list holds, so both hits and evictions happen.
         cap = (cfg_tlb == '0) ? 1 : ((int'(cfg_tlb) > TLB_DEPTH) ? TLB_DEPTH : int'(cfg_tlb));
         pool_n = cap + 3;
         max_page = 32'hFFFF_FFFF / ((cfg_ps == '0) ? 32'd1 : 32'(cfg_ps));
         for (int k = 0; k < pool_n; k++) begin
            r = $urandom_range(5);
            pool[k] = (r == 0) ? 32'd0 : ((r == 1) ? max_page : $urandom_range(max_page, 0));
         end

         items = ITEMS_PER_PHASE;
         if (ph == 2) begin
            // Hold the response side off while words keep coming, then let it all drain.
            hold_requests++;
            r = send_idle_pct;
            send_idle_pct = 0;
            repeat (BURST_ITEMS) begin
               pg = pool[$urandom_range(pool_n - 1)];
               send_word($urandom_range(1) ? FUNC_FILL : FUNC_TRANSLATE, pool_address(pg),
                         16'($urandom));
            end
            send_idle_pct = r;
            drain();
            items = ITEMS_PER_PHASE - BURST_ITEMS;
         end

         repeat (items) begin
            r  = $urandom_range(99);
            pg = pool[$urandom_range(pool_n - 1)];
            if (r < 50)      send_word(FUNC_TRANSLATE, pool_address(pg), 16'($urandom));
            else if (r < 75) send_word(FUNC_FILL, pool_address(pg), 16'($urandom));
            else if (r < 78) send_word(FUNC_FLUSH, $urandom, 16'($urandom));
            else if (r < 92) send_word(FUNC_TRANSLATE, $urandom, 16'($urandom));
            else if (r < 97) send_word(FUNC_FILL, $urandom, 16'($urandom));
            else             send_word(FUNC_UNUSED, $urandom, 16'($urandom));
         end
      end

      drain();
      repeat (END_SETTLE) @(negedge clock);
      $display("Run sent %0d request words and %0d register writes; %0d translations hit.",
               words_sent, regs_written, hits_seen);
      $display("Both policies, clamped sizes, long back-pressure and idle gaps were covered.");
      if (mismatches == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin : watchdog
      #30_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
